// ----- rtl/core/utu_pkg.sv -----
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
`timescale 1ns / 1ps
package utu_pkg;

  typedef enum logic [1:0] {
    CAUSE_ZERO     = 2'd0,
    CAUSE_INVALID  = 2'd1,
    CAUSE_CAPACITY = 2'd2,
    CAUSE_RANGE    = 2'd3
  } stop_cause_t;

  localparam int unsigned PointW = 31;
  localparam logic [PointW-1:0] MaxPoint = PointW'(32'h0010_FFFF);
  localparam logic [PointW-1:0] BmpMax = PointW'(32'h0000_FFFF);
  localparam logic [5:0] HiSurrTag = 6'b110110;
  localparam logic [5:0] LoSurrTag = 6'b110111;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW = $clog2(QueueDepth);
  localparam int unsigned QueueCntW = QueuePtrW + 1;

  localparam int unsigned CfgIndexW = 1;
  localparam logic [CfgIndexW-1:0] RegOutCapacity = 1'd0;
  localparam logic [CfgIndexW-1:0] RegCountOnly = 1'd1;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        is_end;
    stop_cause_t stop_cause;
    logic [15:0] unit_count;
    logic        last;
  } result_t;

  // results produced by one byte, handed to the queue
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

// ----- rtl/core/utf8_to_utf16_transcoder_unit.sv -----
// Top level of the UTF-8 to UTF-16 stream transcoder.
//
//   channel  dir  payload
//   s_*      in   tdata[7:0] in_byte
//   m_*      out  tdata code_unit, stop_cause, unit_count; tuser is_end; tlast last
//   cfg_*    in   index 0 out_capacity, index 1 count_only
//
// One byte per cycle while the queue has room: a request is registered,
// decoded combinationally and its results land in a four-entry result queue.
// A surrogate pair leaves as two code units. Input stalls only while the queue
// has under two free slots. Reset clears decoder state, in_valid, config, queue.
`timescale 1ns / 1ps
module utf8_to_utf16_transcoder_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // [7:0] in_byte
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [39:0]                     m_tdata,   // [15:0] code_unit, [17:16] stop_cause,
                                                     // [33:18] unit_count, [39:34] zero
  output logic                            m_tuser,   // [0] is_end
  output logic                            m_tlast,
  input  logic                            cfg_we,
  input  logic [utu_pkg::CfgIndexW-1:0]   cfg_index,
  input  logic [15:0]                     cfg_data
);

  logic               in_valid;
  logic [7:0]         in_byte;
  logic               advance;
  logic               room;
  logic [15:0]        out_capacity;
  logic               count_only;
  utu_pkg::push_t     push;
  utu_pkg::result_t   out_res;

  assign advance  = in_valid && room;
  assign s_tready = !in_valid || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) in_byte <= s_tdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_capacity <= 16'hFFFF;
      count_only   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        utu_pkg::RegOutCapacity: out_capacity <= cfg_data;
        utu_pkg::RegCountOnly:   count_only <= cfg_data[0];
        default: ;
      endcase
    end
  end

  utu_decode u_decode (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .in_byte      (in_byte),
    .out_capacity (out_capacity),
    .count_only   (count_only),
    .push         (push)
  );

  utu_result_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_en   (advance),
    .push      (push),
    .room      (room),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  assign m_tdata = {6'd0, out_res.unit_count, out_res.stop_cause, out_res.code_unit};
  assign m_tuser = out_res.is_end;
  assign m_tlast = out_res.last;

endmodule

// ----- rtl/core/utu_decode.sv -----
// Decoder state and per-byte UTF-8 to UTF-16 conversion logic.
`timescale 1ns / 1ps
module utu_decode (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        advance,
  input  logic [7:0]                  in_byte,
  input  logic [15:0]                 out_capacity,
  input  logic                        count_only,
  output utu_pkg::push_t              push
);

  logic [2:0]                  bytes_remaining, bytes_remaining_next;
  logic [utu_pkg::PointW-1:0]  partial_point, partial_point_next;
  logic [15:0]                 units_done, units_done_next;
  logic                        halted, halted_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_remaining <= '0;
      partial_point   <= '0;
      units_done      <= '0;
      halted          <= 1'b0;
    end else if (advance) begin
      bytes_remaining <= bytes_remaining_next;
      partial_point   <= partial_point_next;
      units_done      <= units_done_next;
      halted          <= halted_next;
    end
  end

  always_comb begin
    logic                       done;
    logic                       stop;
    logic                       stop_halt;
    utu_pkg::stop_cause_t       cause;
    logic [utu_pkg::PointW-1:0] cp;
    logic                       pair;
    logic [16:0]                sum;
    logic [16:0]                limit;
    logic [19:0]                offs;

    done      = 1'b0;
    stop      = 1'b0;
    stop_halt = 1'b0;
    cause     = utu_pkg::CAUSE_ZERO;
    cp        = '0;
    pair      = 1'b0;
    sum       = '0;
    limit     = '0;
    offs      = '0;

    bytes_remaining_next = bytes_remaining;
    partial_point_next   = partial_point;
    units_done_next      = units_done;
    halted_next          = halted;
    push                 = '0;

    if (halted) begin
      if (in_byte == 8'h00) halted_next = 1'b0;
    end else if (bytes_remaining == 3'd0) begin
      if (in_byte == 8'h00) begin
        stop = 1'b1;
        cause = utu_pkg::CAUSE_ZERO;
      end else if (in_byte[7] == 1'b0) begin
        cp = utu_pkg::PointW'(in_byte);
        done = 1'b1;
      end else if (in_byte[7:6] == 2'b10) begin
        stop = 1'b1;
        stop_halt = 1'b1;
        cause = utu_pkg::CAUSE_INVALID;
      end else if (in_byte[7:5] == 3'b110) begin
        partial_point_next = utu_pkg::PointW'(in_byte[4:0]);
        bytes_remaining_next = 3'd1;
      end else if (in_byte[7:4] == 4'b1110) begin
        partial_point_next = utu_pkg::PointW'(in_byte[3:0]);
        bytes_remaining_next = 3'd2;
      end else if (in_byte[7:3] == 5'b11110) begin
        partial_point_next = utu_pkg::PointW'(in_byte[2:0]);
        bytes_remaining_next = 3'd3;
      end else if (in_byte[7:2] == 6'b111110) begin
        partial_point_next = utu_pkg::PointW'(in_byte[1:0]);
        bytes_remaining_next = 3'd4;
      end else if (in_byte[7:1] == 7'b1111110) begin
        partial_point_next = utu_pkg::PointW'(in_byte[0]);
        bytes_remaining_next = 3'd5;
      end else begin
        stop = 1'b1;
        stop_halt = 1'b1;
        cause = utu_pkg::CAUSE_INVALID;
      end
    end else begin
      if (in_byte[7:6] != 2'b10) begin
        stop = 1'b1;
        stop_halt = (in_byte != 8'h00);
        cause = utu_pkg::CAUSE_INVALID;
      end else begin
        cp = {partial_point[utu_pkg::PointW-7:0], in_byte[5:0]};
        bytes_remaining_next = bytes_remaining - 3'd1;
        if (bytes_remaining == 3'd1) done = 1'b1;
        else partial_point_next = cp;
      end
    end

    if (done) begin
      partial_point_next = '0;
      pair = (cp > utu_pkg::BmpMax);
      sum = {1'b0, units_done} + (pair ? 17'd2 : 17'd1);
      limit = (out_capacity == 16'd0) ? 17'd0 : {1'b0, out_capacity} - 17'd1;
      offs = cp[19:0] - 20'h10000;
      if (cp > utu_pkg::MaxPoint) begin
        stop = 1'b1;
        stop_halt = 1'b1;
        cause = utu_pkg::CAUSE_RANGE;
      end else if (count_only) begin
        units_done_next = sum[16] ? 16'hFFFF : sum[15:0];
      end else if (sum > limit) begin
        stop = 1'b1;
        stop_halt = 1'b1;
        cause = utu_pkg::CAUSE_CAPACITY;
      end else if (!pair) begin
        units_done_next = sum[15:0];
        push.count = 2'd1;
        push.first.code_unit = cp[15:0];
        push.first.unit_count = sum[15:0];
        push.first.last = 1'b1;
      end else begin
        units_done_next = sum[15:0];
        push.count = 2'd2;
        push.first.code_unit = {utu_pkg::HiSurrTag, offs[19:10]};
        push.first.unit_count = units_done + 16'd1;
        push.second.code_unit = {utu_pkg::LoSurrTag, offs[9:0]};
        push.second.unit_count = sum[15:0];
        push.second.last = 1'b1;
      end
    end

    if (stop) begin
      push = '0;
      push.count = 2'd1;
      push.first.is_end = 1'b1;
      push.first.stop_cause = cause;
      push.first.unit_count = units_done;
      push.first.last = 1'b1;
      bytes_remaining_next = '0;
      partial_point_next = '0;
      units_done_next = '0;
      halted_next = stop_halt;
    end
  end

endmodule

// ----- rtl/core/utu_result_queue.sv -----
// Small result queue taking up to two results per cycle, one out per cycle while out_ready is high.
`timescale 1ns / 1ps
module utu_result_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push_en,
  input  utu_pkg::push_t       push,
  output logic                 room,
  output logic                 out_valid,
  input  logic                 out_ready,
  output utu_pkg::result_t     out_res
);

  utu_pkg::result_t                 mem [utu_pkg::QueueDepth];
  logic [utu_pkg::QueuePtrW-1:0]    wr_ptr;
  logic [utu_pkg::QueuePtrW-1:0]    rd_ptr;
  logic [utu_pkg::QueueCntW-1:0]    count;
  logic                             pop;
  logic [utu_pkg::QueueCntW-1:0]    n_in;

  assign pop       = out_valid && out_ready;
  assign n_in      = push_en ? utu_pkg::QueueCntW'(push.count) : '0;
  assign out_valid = (count != '0);
  assign out_res   = mem[rd_ptr];
  // two free slots needed for a surrogate pair
  assign room      = (count <= utu_pkg::QueueCntW'(utu_pkg::QueueDepth - 2));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + utu_pkg::QueuePtrW'(n_in);
      if (pop) rd_ptr <= rd_ptr + utu_pkg::QueuePtrW'(1);
      count <= count + n_in - utu_pkg::QueueCntW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push_en && push.count != 2'd0) mem[wr_ptr] <= push.first;
    if (push_en && push.count == 2'd2) mem[wr_ptr + utu_pkg::QueuePtrW'(1)] <= push.second;
  end

endmodule
